### rtl/edd_pkg.sv
`timescale 1ns / 1ps

package edd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CFG_W  = 11;
    localparam int CFG_IDX_W = 1;
    localparam int GRAY_W = 8;
    localparam int ERR_W  = 11;
    localparam int SUM_W  = ERR_W + 2;
    localparam int PROD_W = ERR_W + 4;

    localparam int THRESHOLD   = 127;
    localparam int WHITE_LEVEL = 255;
    localparam int ERR_MAX     = (1 << (ERR_W - 1)) - 1;
    localparam int ERR_MIN     = -(1 << (ERR_W - 1));

    localparam logic [2:0] SHARE_RIGHT      = 3'd7;
    localparam logic [2:0] SHARE_BELOW_LEFT = 3'd3;
    localparam logic [2:0] SHARE_BELOW      = 3'd5;
    localparam logic [2:0] SHARE_DIAG       = 3'd1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_IMAGE_WIDTH  = 1'd0;
    localparam cfg_idx_t REG_IMAGE_HEIGHT = 1'd1;

    localparam cfg_data_t WIDTH_RESET  = 11'd128;
    localparam cfg_data_t HEIGHT_RESET = 11'd64;

    typedef logic [COL_W-1:0] col_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [GRAY_W-1:0] gray_t;
    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        gray_t gray;
        col_t  col;
        logic  first_col;
        logic  last_col;
        logic  first_row;
        logic  last_row;
    } stage_t;

    typedef struct packed {
        logic en;
        col_t addr;
        err_t data;
    } lb_write_t;

    function automatic col_t last_col_index(input cfg_data_t v);
        if (v == '0)
            return '0;
        else if (int'(v) > MAX_WIDTH)
            return col_t'(MAX_WIDTH - 1);
        else
            return col_t'(v - CFG_W'(1));
    endfunction

    function automatic row_t last_row_index(input cfg_data_t v);
        if (v == '0)
            return '0;
        else if (int'(v) > MAX_HEIGHT)
            return row_t'(MAX_HEIGHT - 1);
        else
            return row_t'(v - CFG_W'(1));
    endfunction

    function automatic err_t sat_err(input sum_t v);
        if (v > SUM_W'(ERR_MAX))
            return err_t'(ERR_MAX);
        else if (v < SUM_W'(ERR_MIN))
            return err_t'(ERR_MIN);
        else
            return err_t'(v);
    endfunction

    // err * k / 16, truncated toward zero
    function automatic err_t share(input err_t e, input logic [2:0] k);
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] biased;
        prod   = PROD_W'(e) * PROD_W'(signed'({1'b0, k}));
        biased = prod[PROD_W-1] ? prod + PROD_W'(15) : prod;
        return err_t'(biased >>> 4);
    endfunction

endpackage

### rtl/edd_pixel_if.sv
`timescale 1ns / 1ps

interface edd_pixel_if import edd_pkg::*;;
    logic  valid;
    logic  ready;
    gray_t gray_level;

    modport source (output valid, output gray_level, input ready);
    modport sink (input valid, input gray_level, output ready);
endinterface

### rtl/edd_result_if.sv
`timescale 1ns / 1ps

interface edd_result_if;
    logic valid;
    logic ready;
    logic pixel_white;
    logic frame_end;

    modport source (output valid, output pixel_white, output frame_end, input ready);
    modport sink (input valid, input pixel_white, input frame_end, output ready);
endinterface

### rtl/edd_cfg_if.sv
`timescale 1ns / 1ps

interface edd_cfg_if import edd_pkg::*;;
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/edd_cfg_regs.sv
`timescale 1ns / 1ps

module edd_cfg_regs
    import edd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    edd_cfg_if.sink      cfg,
    output col_t         width_last,
    output row_t         height_last
);

    cfg_data_t width_reg;
    cfg_data_t height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign width_last  = last_col_index(width_reg);
    assign height_last = last_row_index(height_reg);

endmodule

### rtl/edd_line_buffer.sv
`timescale 1ns / 1ps

module edd_line_buffer
    import edd_pkg::*;
(
    input  logic      clk,
    input  lb_write_t wr,
    input  logic      rd_en,
    input  col_t      rd_addr,
    input  col_t      hold_addr,
    output err_t      rd_data
);

    err_t mem [MAX_WIDTH];
    err_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
    end

    // read data follows writes to its address until the pixel is consumed
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && wr.addr == rd_addr)
                rd_data_reg <= wr.data;
            else
                rd_data_reg <= mem[rd_addr];
        end
        else if (wr.en && wr.addr == hold_addr)
        begin
            rd_data_reg <= wr.data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/edd_scan.sv
`timescale 1ns / 1ps

module edd_scan
    import edd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    edd_pixel_if.sink pixels,
    input  col_t      width_last,
    input  row_t      height_last,
    input  logic      advance,
    output logic      stage_valid,
    output stage_t    stage,
    output logic      rd_en,
    output col_t      rd_addr
);

    col_t   col_reg;
    col_t   col_next;
    row_t   row_reg;
    row_t   row_next;
    logic   stage_valid_reg;
    stage_t stage_reg;
    logic   accept;
    logic   last_col;
    logic   last_row;

    assign pixels.ready = !stage_valid_reg || advance;
    assign accept       = pixels.valid && pixels.ready;
    assign last_col     = col_reg >= width_last;
    assign last_row     = row_reg >= height_last;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.gray      <= pixels.gray_level;
            stage_reg.col       <= col_reg;
            stage_reg.first_col <= col_reg == '0;
            stage_reg.last_col  <= last_col;
            stage_reg.first_row <= row_reg == '0;
            stage_reg.last_row  <= last_row;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;
    assign rd_en       = accept;
    assign rd_addr     = col_reg;

endmodule

### rtl/edd_diffuse.sv
`timescale 1ns / 1ps

module edd_diffuse
    import edd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          stage_valid,
    input  stage_t        stage,
    input  err_t          above_raw,
    output logic          advance,
    output lb_write_t     lb_wr,
    edd_result_if.source  results
);

    err_t right_carry_reg;
    err_t diag_carry_reg;
    err_t pending_below_reg;
    logic defer_valid_reg;
    col_t defer_addr_reg;
    err_t defer_data_reg;
    logic out_valid_reg;
    logic pixel_white_reg;
    logic frame_end_reg;

    err_t left;
    err_t above;
    err_t part_prev;
    err_t diag;
    err_t corrected;
    logic white;
    err_t err;
    err_t below_left_val;
    err_t below_val;
    logic main_we;
    logic edge_we;
    logic lb_busy;

    // a one-column row right after a deferred write waits for the write port
    assign lb_busy = defer_valid_reg && stage.first_col && stage.last_col;
    assign advance = stage_valid && !lb_busy && (!out_valid_reg || results.ready);

    always_comb
    begin
        left      = stage.first_col ? '0 : right_carry_reg;
        above     = stage.first_row ? '0 : above_raw;
        part_prev = stage.first_col ? '0 : pending_below_reg;
        diag      = stage.first_col ? '0 : diag_carry_reg;
        corrected = sat_err(SUM_W'(signed'({1'b0, stage.gray})) + SUM_W'(left)
                            + SUM_W'(above));
        white     = corrected > err_t'(THRESHOLD);
        err       = white ? corrected - err_t'(WHITE_LEVEL) : corrected;
        below_left_val = sat_err(SUM_W'(part_prev)
                                 + SUM_W'(share(err, SHARE_BELOW_LEFT)));
        below_val      = sat_err(SUM_W'(diag) + SUM_W'(share(err, SHARE_BELOW)));
        main_we   = advance && !stage.last_row && !stage.first_col;
        edge_we   = advance && !stage.last_row && stage.first_col && stage.last_col;
    end

    // end-of-row entry goes out in the following cycle, when the column-zero pixel writes nothing
    // a one-column row writes its own entry at once
    always_comb
    begin
        if (main_we)
        begin
            lb_wr.en   = 1'b1;
            lb_wr.addr = stage.col - COL_W'(1);
            lb_wr.data = below_left_val;
        end
        else if (edge_we)
        begin
            lb_wr.en   = 1'b1;
            lb_wr.addr = stage.col;
            lb_wr.data = below_val;
        end
        else
        begin
            lb_wr.en   = defer_valid_reg;
            lb_wr.addr = defer_addr_reg;
            lb_wr.data = defer_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_carry_reg   <= '0;
            diag_carry_reg    <= '0;
            pending_below_reg <= '0;
            defer_valid_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            defer_valid_reg <= advance && stage.last_col && !stage.last_row
                               && !stage.first_col;
            if (advance)
            begin
                right_carry_reg   <= stage.last_col ? '0 : share(err, SHARE_RIGHT);
                diag_carry_reg    <= stage.last_col ? '0 : share(err, SHARE_DIAG);
                pending_below_reg <= (stage.last_col || stage.last_row) ? '0 : below_val;
                out_valid_reg     <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            defer_addr_reg  <= stage.col;
            defer_data_reg  <= below_val;
            pixel_white_reg <= white;
            frame_end_reg   <= stage.last_col && stage.last_row;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.pixel_white = pixel_white_reg;
    assign results.frame_end   = frame_end_reg;

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !((main_we || edge_we) && defer_valid_reg))
        else $error("line buffer write collision");

    a_defer_once: assert property (@(posedge clk) disable iff (!rst_n)
        defer_valid_reg |=> !defer_valid_reg)
        else $error("deferred write lasted more than one cycle");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result not presented after pixel completed");

    a_defer_first_col: assert property (@(posedge clk) disable iff (!rst_n)
        (defer_valid_reg && stage_valid) |-> stage.first_col || !advance)
        else $error("deferred write overlaps a non-first column pixel");

endmodule

### rtl/error_diffusion_dither.sv
`timescale 1ns / 1ps

// Floyd-Steinberg error diffusion of 8-bit gray pixels in raster order to one black/white
// pixel each. Throughput is one pixel per clock while results are taken, sustained across
// row and frame ends but for a single bubble when the width is cut to one mid-row. Each
// pixel's result is registered in the input stage (which also reads the 1024 x 11-bit line
// buffer) and then in the result register. The line buffer has one write and one read port
// and needs no clearing pass after reset, since row zero ignores what it reads. Image
// width and height go through the configuration channel; the user must write them only while
// the block is idle, which the block itself does not enforce. Zero is taken as one, past 1024 as 1024.
module error_diffusion_dither
    import edd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    edd_cfg_if.sink      cfg,
    edd_pixel_if.sink    pixels,
    edd_result_if.source results
);

    col_t      width_last;
    row_t      height_last;
    logic      advance;
    logic      stage_valid;
    stage_t    stage;
    logic      rd_en;
    col_t      rd_addr;
    err_t      above_raw;
    lb_write_t lb_wr;

    edd_cfg_regs u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .width_last  (width_last),
        .height_last (height_last)
    );

    edd_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pixels),
        .width_last  (width_last),
        .height_last (height_last),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage       (stage),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr)
    );

    edd_line_buffer u_line_buffer (
        .clk       (clk),
        .wr        (lb_wr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .hold_addr (stage.col),
        .rd_data   (above_raw)
    );

    edd_diffuse u_diffuse (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .above_raw   (above_raw),
        .advance     (advance),
        .lb_wr       (lb_wr),
        .results     (results)
    );

endmodule

### sim/tb_error_diffusion_dither.sv
`timescale 1ns / 1ps

module tb_error_diffusion_dither;
    import edd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PIXELS = 400;
    localparam int QUIET_PIXELS  = 150;
    localparam int REPORT_LIMIT  = 20;
    localparam int DRAIN_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic pixel_white;
        logic frame_end;
    } dither_out_t;

    typedef enum int {
        TONE_NOISE,
        TONE_FLAT,
        TONE_EDGE,
        TONE_EXTREME,
        TONE_RAMP
    } tone_t;

    logic clk = 1'b0;
    logic rst_n;

    edd_cfg_if    cfg_ch ();
    edd_pixel_if  pixel_ch ();
    edd_result_if result_ch ();

    error_diffusion_dither uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .pixels  (pixel_ch),
        .results (result_ch)
    );

    // dither state mirrored by the testbench
    cfg_data_t   width_reg;
    cfg_data_t   height_reg;
    err_t        line_errors [MAX_WIDTH];
    err_t        carry_right;
    err_t        carry_diag;
    err_t        below_acc;
    col_t        col_pos;
    row_t        row_pos;
    dither_out_t expected_pixels [$];

    int          errors        = 0;
    int          results_seen  = 0;
    int          whites_seen   = 0;
    int          frames_seen   = 0;
    int          pixels_sent   = 0;
    int          reg_writes    = 0;
    int          cycle_count   = 0;
    bit          idle_on       = 1'b1;
    int          src_gap_pct   = 25;
    int          flat_level    = 0;
    int unsigned sink_hold     = 0;
    dither_out_t front;

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    function automatic int eff_size(cfg_data_t v, int limit);
        if (v == '0)
            return 1;
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    function automatic int clip_err(int v);
        if (v > ERR_MAX)
            return ERR_MAX;
        if (v < ERR_MIN)
            return ERR_MIN;
        return v;
    endfunction

    function automatic int fraction16(int e, logic [2:0] num);
        return (e * int'(num)) / 16;
    endfunction

    function automatic void dither_reset();
        width_reg   = WIDTH_RESET;
        height_reg  = HEIGHT_RESET;
        carry_right = '0;
        carry_diag  = '0;
        below_acc   = '0;
        col_pos     = '0;
        row_pos     = '0;
        foreach (line_errors[i])
            line_errors[i] = '0;
    endfunction

    function automatic dither_out_t dither_pixel(gray_t gray);
        int          w;
        int          h;
        int          x;
        bit          last_col;
        bit          last_row;
        bit          first_col;
        int          left;
        int          above;
        int          part_prev;
        int          diag;
        int          corrected;
        int          err;
        bit          white;
        dither_out_t r;
        w         = eff_size(width_reg, MAX_WIDTH);
        h         = eff_size(height_reg, MAX_HEIGHT);
        x         = int'(col_pos);
        last_col  = x >= w - 1;
        last_row  = int'(row_pos) >= h - 1;
        first_col = (x == 0);
        left      = first_col ? 0 : int'(carry_right);
        above     = (row_pos == '0) ? 0 : int'(line_errors[x]);
        part_prev = first_col ? 0 : int'(below_acc);
        diag      = first_col ? 0 : int'(carry_diag);
        corrected = clip_err(int'(gray) + left + above);
        white     = corrected > THRESHOLD;
        err       = corrected - (white ? WHITE_LEVEL : 0);
        if (!last_row)
        begin
            if (!first_col)
                line_errors[x - 1] = err_t'(clip_err(part_prev
                                     + fraction16(err, SHARE_BELOW_LEFT)));
            below_acc = err_t'(clip_err(diag + fraction16(err, SHARE_BELOW)));
            if (last_col)
                line_errors[x] = below_acc;
        end
        else
            below_acc = '0;
        carry_diag    = last_col ? '0 : err_t'(fraction16(err, SHARE_DIAG));
        carry_right   = last_col ? '0 : err_t'(fraction16(err, SHARE_RIGHT));
        r.pixel_white = white;
        r.frame_end   = last_col && last_row;
        if (last_col)
        begin
            col_pos   = '0;
            below_acc = '0;
            row_pos   = last_row ? '0 : row_pos + 1'b1;
        end
        else
            col_pos = col_pos + 1'b1;
        return r;
    endfunction

    function automatic gray_t tone_level(tone_t tone, int k);
        case (tone)
            TONE_FLAT:    return gray_t'(flat_level);
            TONE_EDGE:    return gray_t'($urandom_range(THRESHOLD + 8, THRESHOLD - 8));
            TONE_EXTREME: return $urandom_range(1, 0) ? gray_t'(WHITE_LEVEL) : '0;
            TONE_RAMP:    return gray_t'((k * 7 + flat_level) % 256);
            default:      return gray_t'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic tone_t pick_tone();
        flat_level = $urandom_range(255, 0);
        return tone_t'($urandom_range(TONE_RAMP, TONE_NOISE));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (errors < REPORT_LIMIT)
            $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
                     $time, what, got, want, results_seen);
        errors++;
    endtask

    // one pixel transfer; returns at a falling edge with valid still high
    task automatic send_pixel(gray_t gray);
        if (idle_on && $urandom_range(99, 0) < src_gap_pct)
        begin
            pixel_ch.valid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(negedge clk);
        end
        pixel_ch.valid      <= 1'b1;
        pixel_ch.gray_level <= gray;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
        expected_pixels.push_back(dither_pixel(gray));
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic run_to_frame_end(tone_t tone);
        int k;
        k = 0;
        do
        begin
            send_pixel(tone_level(tone, k));
            k++;
        end
        while (col_pos != '0 || row_pos != '0);
    endtask

    task automatic wait_drained();
        pixel_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_frame_size(int w, int h);
        write_reg(REG_IMAGE_WIDTH, cfg_data_t'(w));
        write_reg(REG_IMAGE_HEIGHT, cfg_data_t'(h));
    endtask

    // reset size, then the height cut short in the middle of a frame
    task automatic test_reset_defaults();
        repeat (int'(WIDTH_RESET))
            send_pixel(tone_level(TONE_NOISE, 0));
        write_reg(REG_IMAGE_HEIGHT, cfg_data_t'(1));
        run_to_frame_end(TONE_NOISE);
    endtask

    task automatic test_directed_pixels();
        gray_t pattern [25];
        pattern = '{8'd0,   8'd255, 8'd127, 8'd128, 8'd1,
                    8'd254, 8'd128, 8'd127, 8'd0,   8'd255,
                    8'd64,  8'd192, 8'd127, 8'd127, 8'd128,
                    8'd255, 8'd255, 8'd255, 8'd0,   8'd0,
                    8'd128, 8'd0,   8'd255, 8'd127, 8'd200};
        set_frame_size(5, 5);
        foreach (pattern[i])
            send_pixel(pattern[i]);
    endtask

    // zero sizes act as one, a height past the maximum clamps to it
    task automatic test_size_extremes();
        set_frame_size(0, 0);
        repeat (3)
            run_to_frame_end(TONE_EXTREME);
        set_frame_size(1, 2047);
        run_to_frame_end(TONE_EDGE);
    endtask

    // the line buffer entries used here were written earlier, so a wider row mid-frame reads known data
    task automatic test_midframe_resize();
        set_frame_size(16, 6);
        repeat (24)
            send_pixel(tone_level(TONE_NOISE, 0));
        write_reg(REG_IMAGE_WIDTH, cfg_data_t'(4));
        repeat (10)
            send_pixel(tone_level(TONE_NOISE, 0));
        write_reg(REG_IMAGE_WIDTH, cfg_data_t'(12));
        repeat (5)
            send_pixel(tone_level(TONE_NOISE, 0));
        write_reg(REG_IMAGE_HEIGHT, cfg_data_t'(2));
        run_to_frame_end(TONE_NOISE);
    endtask

    task automatic test_random_frames();
        int    start;
        int    pick;
        int    w;
        int    h;
        tone_t tone;
        start = pixels_sent;
        while (pixels_sent < start + RANDOM_PIXELS)
        begin
            if (pixels_sent >= start + RANDOM_PIXELS - QUIET_PIXELS)
                idle_on = 1'b0;
            if ($urandom_range(1, 0) == 1)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 10)
                    w = $urandom_range(2, 0);
                else if (pick < 80)
                    w = $urandom_range(24, 1);
                else
                    w = $urandom_range(96, 25);
                h = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(10, 1);
                set_frame_size(w, h);
            end
            case ($urandom_range(2, 0))
                0:       src_gap_pct = 0;
                1:       src_gap_pct = 15;
                default: src_gap_pct = 50;
            endcase
            tone = pick_tone();
            run_to_frame_end(tone);
        end
    endtask

    // result side ready with random stall bursts while idle_on is set, else always ready
    always @(negedge clk)
    begin
        if (sink_hold != 0)
            sink_hold = sink_hold - 1;
        else if (!idle_on)
            result_ch.ready <= 1'b1;
        else if ($urandom_range(2, 0) == 0)
        begin
            result_ch.ready <= 1'b0;
            sink_hold = $urandom_range(11, 1) - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            sink_hold = $urandom_range(30, 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (result_ch.pixel_white === 1'b1)
                whites_seen++;
            if (result_ch.frame_end === 1'b1)
                frames_seen++;
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected result transfer", 1, 0);
            else
            begin
                front = expected_pixels.pop_front();
                if (result_ch.pixel_white !== front.pixel_white)
                    report_mismatch("pixel_white", result_ch.pixel_white, front.pixel_white);
                if (result_ch.frame_end !== front.frame_end)
                    report_mismatch("frame_end", result_ch.frame_end, front.frame_end);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     CYCLE_LIMIT, expected_pixels.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        pixel_ch.valid      = 1'b0;
        pixel_ch.gray_level = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_IMAGE_WIDTH;
        cfg_ch.data         = '0;
        result_ch.ready     = 1'b0;
        dither_reset();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_directed_pixels();
        test_size_extremes();
        test_midframe_resize();
        test_random_frames();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_pixels.size() != 0)
            report_mismatch("results never delivered", 0, expected_pixels.size());
        $display("%0d gray pixels dithered over %0d frames with %0d size writes,",
                 pixels_sent, frames_seen, reg_writes);
        $display("%0d results checked (%0d white), %0d mismatches",
                 results_seen, whites_seen, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
rtl/edd_pkg.sv
rtl/edd_pixel_if.sv
rtl/edd_result_if.sv
rtl/edd_cfg_if.sv
rtl/edd_cfg_regs.sv
rtl/edd_line_buffer.sv
rtl/edd_scan.sv
rtl/edd_diffuse.sv
rtl/error_diffusion_dither.sv
sim/tb_error_diffusion_dither.sv
